### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Opcodes, character codes, register indexes, default geometry and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = ATTR_W + CHAR_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // control characters
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_ATTR = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input word
    logic row_inc;    // cursor down one row
    logic col_zero;   // cursor to column 0
    logic col_inc;    // cursor right one column
    logic home;       // cursor and published cursor to 0
    logic publish;    // publish cursor position
    logic wr_char;    // write character at cursor
    logic wr_copy;    // write read-back cell one row up
    logic wr_blank;   // write blank cell at sweep counter
    logic rd_copy;    // read cell one row below sweep counter
    logic cnt_clr;    // sweep counter to 0 / fill start
    logic cnt_inc;    // sweep counter step
    logic resp_cell;  // capture read data as result
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_put;
    logic is_clear;
    logic is_read;
    logic is_lf;
    logic is_cr;
    logic col_full;
    logic at_bottom;
    logic last;
    logic idx_ok;
    logic cnt_zero;
    logic cnt_copy_end;
    logic cnt_last;
  } tcw_status_t;

endpackage

### design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: controller state machine of the text console writer
// Sequences character writes, scroll copy/fill sweeps, clear sweeps and
// cell reads, and raises the result strobe when a word is finished.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  tcw_pkg::tcw_status_t st,
  output tcw_pkg::tcw_cmd_t    cmd
);
  import tcw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_WRITE  = 7'b0000100,
    S_READ   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_CLEAR  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   done_next;
  logic   printable;
  logic   need_lf;

  assign printable = !st.is_lf && !st.is_cr;
  assign need_lf   = st.is_lf || (printable && st.col_full);
  assign busy      = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.is_clear) begin
          cmd.home    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = S_CLEAR;
        end else if (st.is_read) begin
          if (st.idx_ok) begin
            state_next = S_READ;
          end else begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end else if (st.is_put) begin
          if (need_lf && st.at_bottom) begin
            cmd.col_zero = printable;
            cmd.cnt_clr  = 1'b1;
            state_next   = S_SCROLL;
          end else if (need_lf) begin
            cmd.row_inc = 1'b1;
            if (printable) begin
              cmd.col_zero = 1'b1;
              state_next   = S_WRITE;
            end else begin
              cmd.publish = st.last;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
          end else if (st.is_cr) begin
            cmd.col_zero = 1'b1;
            cmd.publish  = st.last;
            done_next    = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.wr_char = 1'b1;
            cmd.col_inc = 1'b1;
            cmd.publish = st.last;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          // unused opcode: report only
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WRITE: begin
        cmd.wr_char = 1'b1;
        cmd.col_inc = 1'b1;
        cmd.publish = st.last;
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end
      S_READ: begin
        cmd.resp_cell = 1'b1;
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end
      S_SCROLL: begin
        // read one row below, write the previous read one row up
        cmd.rd_copy = !st.cnt_copy_end;
        cmd.wr_copy = !st.cnt_zero;
        if (st.cnt_copy_end) begin
          state_next = S_FILL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FILL: begin
        cmd.wr_blank = 1'b1;
        if (st.cnt_last) begin
          if (printable) begin
            state_next = S_WRITE;
          end else begin
            cmd.publish = st.last;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_CLEAR: begin
        cmd.wr_blank = 1'b1;
        if (st.cnt_last) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and strobe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

### design/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, configuration, sweep counter and cell store
// Holds the captured word, cursor and published cursor, attribute
// registers and the cell ram with its address and data selection.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS,
  localparam int CELLS  = ROWS * COLS,
  localparam int COL_W  = $clog2(COLS + 1),
  localparam int ROW_W  = $clog2(ROWS),
  localparam int ADDR_W = $clog2(CELLS),
  localparam int POS_W  = $clog2(CELLS + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [tcw_pkg::OP_W-1:0]              opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]            char_code,
  input  logic                                  last_char,
  input  logic [POS_W-1:0]                      cell_index,
  input  logic                                  cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]             cfg_data,
  input  tcw_pkg::tcw_cmd_t                     cmd,
  output tcw_pkg::tcw_status_t                  st,
  output logic [tcw_pkg::CELL_W-1:0]            cell_data,
  output logic [COL_W-1:0]                      cursor_col,
  output logic [ROW_W-1:0]                      cursor_row,
  output logic [POS_W-1:0]                      hw_cursor_pos
);
  import tcw_pkg::*;

  // captured word
  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] ch_q;
  logic              last_q;
  logic [POS_W-1:0]  idx_q;

  // cursor and configuration
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ADDR_W-1:0] row_base, row_base_next;
  logic [POS_W-1:0]  hw_pos;
  logic [ATTR_W-1:0] text_attr;
  logic [ATTR_W-1:0] fill_attr;
  logic [ADDR_W-1:0] cnt;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic [CELL_W-1:0] cell_q;
  logic [ADDR_W-1:0] cur_addr;

  // status toward the controller
  assign st.is_put       = (op_q == OP_PUT);
  assign st.is_clear     = (op_q == OP_CLEAR);
  assign st.is_read      = (op_q == OP_READ);
  assign st.is_lf        = (ch_q == CH_LF);
  assign st.is_cr        = (ch_q == CH_CR);
  assign st.col_full     = (col >= COL_W'(COLS));
  assign st.at_bottom    = (row == ROW_W'(ROWS - 1));
  assign st.last         = last_q;
  assign st.idx_ok       = (idx_q < POS_W'(CELLS));
  assign st.cnt_zero     = (cnt == '0);
  assign st.cnt_copy_end = (cnt == ADDR_W'(CELLS - COLS));
  assign st.cnt_last     = (cnt == ADDR_W'(CELLS - 1));

  // cursor next values
  always_comb begin
    col_next      = col;
    row_next      = row;
    row_base_next = row_base;
    if (cmd.home || cmd.col_zero) begin
      col_next = '0;
    end else if (cmd.col_inc) begin
      col_next = col + COL_W'(1);
    end
    if (cmd.home) begin
      row_next      = '0;
      row_base_next = '0;
    end else if (cmd.row_inc) begin
      row_next      = row + ROW_W'(1);
      row_base_next = row_base + ADDR_W'(COLS);
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      ch_q   <= char_code;
      last_q <= last_char;
      idx_q  <= cell_index;
    end
  end

  // cursor, published cursor and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
      hw_pos   <= '0;
      cnt      <= '0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      row_base <= row_base_next;
      if (cmd.home) begin
        hw_pos <= '0;
      end else if (cmd.publish) begin
        hw_pos <= POS_W'(row_base_next) + POS_W'(col_next);
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + ADDR_W'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_W'(7);
      fill_attr <= ATTR_W'(7);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEXT_ATTR: text_attr <= cfg_data[ATTR_W-1:0];
        REG_FILL_ATTR: fill_attr <= cfg_data[ATTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ram address and data selection
  assign cur_addr  = row_base + ADDR_W'(col);
  assign ram_we    = cmd.wr_char || cmd.wr_copy || cmd.wr_blank;
  assign ram_raddr = cmd.rd_copy ? (cnt + ADDR_W'(COLS)) : idx_q[ADDR_W-1:0];

  always_comb begin
    ram_waddr = cnt;
    ram_wdata = {fill_attr, CHAR_W'(0)};
    if (cmd.wr_char) begin
      ram_waddr = cur_addr;
      ram_wdata = {text_attr, ch_q};
    end else if (cmd.wr_copy) begin
      ram_waddr = cnt - ADDR_W'(1);
      ram_wdata = ram_rdata;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cell_q <= '0;
    end else if (cmd.resp_cell) begin
      cell_q <= ram_rdata;
    end
  end

  assign cell_data     = cell_q;
  assign cursor_col    = col;
  assign cursor_row    = row;
  assign hw_cursor_pos = hw_pos;

endmodule

### design/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// Character cell store of ROWS x COLS cells with cursor, wrap, scroll,
// clear and cell read.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and must be taken then since
// the receiver cannot hold it off. A line feed or wrap on the last row
// scrolls the whole store, and clear sweeps every cell; both sweeps are
// paced by the single write port of the cell ram, which moves one cell per
// cycle. Cells read before any clear or write return undefined data.
// Attribute registers may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS,
  localparam int CELLS = ROWS * COLS,
  localparam int COL_W = $clog2(COLS + 1),
  localparam int ROW_W = $clog2(ROWS),
  localparam int POS_W = $clog2(CELLS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tcw_pkg::OP_W-1:0]      opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  input  logic [POS_W-1:0]              cell_index,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data,
  output logic [COL_W-1:0]              cursor_col,
  output logic [ROW_W-1:0]              cursor_row,
  output logic [POS_W-1:0]              hw_cursor_pos
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t st;

  // controller
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .st    (st),
    .cmd   (cmd)
  );

  // datapath
  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .char_code     (char_code),
    .last_char     (last_char),
    .cell_index    (cell_index),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .st            (st),
    .cell_data     (cell_data),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .hw_cursor_pos (hw_cursor_pos)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: text console writer
// Drives command words into the console engine, predicts cursor, published
// cursor and cell contents in a local screen image, and checks every result
// word against it. A short directed table covers the edges, then random
// phases under several attribute settings exercise wrap, scroll and clear.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int COLS         = DEF_COLS;
  localparam int ROWS         = DEF_ROWS;
  localparam int CELLS        = COLS * ROWS;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 105;
  localparam int DRAIN_CYCLES = CELLS + 16;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int PLAN_LEN     = 24;

  // opcode with no function, only in the testbench
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [15:0] cell_val;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] hw;
  } console_status_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  ch;
    bit          last;
    logic [10:0] idx;
    int          reps;
    bit          typed;
    logic [15:0] w_cell;
    logic [6:0]  w_col;
    logic [4:0]  w_row;
    logic [10:0] w_hw;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [7:0]  char_code;
  logic        last_char;
  logic [10:0] cell_index;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        done;
  logic [15:0] cell_data;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] hw_cursor_pos;

  // local screen image and cursor
  logic [15:0] screen_img [CELLS];
  int          cur_col;
  int          cur_row;
  int          hw_pos;
  logic [7:0]  text_attr_q;
  logic [7:0]  fill_attr_q;

  console_status_t pending_status [$];
  int     errors;
  longint cycles;
  bit     gaps_on;

  // directed table: typed expectations only where they are obvious
  plan_row_t plan [PLAN_LEN] = '{
    '{OP_NONE,  CH_LF, 1'b1, 11'd0,    1, 1'b1, 16'h0000, 7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd2047, 1, 1'b1, 16'h0000, 7'd0,  5'd0,  11'd0},
    '{OP_CLEAR, 8'h00, 1'b1, 11'd2047, 1, 1'b1, 16'h0000, 7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd0,    1, 1'b1, 16'h0700, 7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd1999, 1, 1'b1, 16'h0700, 7'd0,  5'd0,  11'd0},
    '{OP_PUT,   8'h41, 1'b1, 11'd0,    1, 1'b1, 16'h0000, 7'd1,  5'd0,  11'd1},
    '{OP_READ,  8'h00, 1'b0, 11'd0,    1, 1'b1, 16'h0741, 7'd1,  5'd0,  11'd1},
    '{OP_PUT,   8'hFF, 1'b0, 11'd0,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_PUT,   8'h00, 1'b0, 11'd0,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_PUT,   8'h80, 1'b1, 11'd0,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd1,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_PUT,   CH_CR, 1'b1, 11'd0,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_PUT,   CH_LF, 1'b1, 11'd0,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd2000, 1, 1'b1, 16'h0000, 7'd0,  5'd1,  11'd80},
    '{OP_PUT,   CH_LF, 1'b0, 11'd0,   23, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_PUT,   8'h78, 1'b1, 11'd0,   80, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_NONE,  8'h00, 1'b0, 11'd0,    1, 1'b1, 16'h0000, 7'd80, 5'd24, 11'd2000},
    '{OP_PUT,   8'h79, 1'b1, 11'd0,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd1920, 1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd1919, 1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd1999, 1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_PUT,   CH_LF, 1'b1, 11'd0,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_READ,  8'h00, 1'b0, 11'd1840, 1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0},
    '{OP_PUT,   CH_CR, 1'b0, 11'd0,    1, 1'b0, 16'h0,    7'd0,  5'd0,  11'd0}
  };

  text_console_writer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .char_code     (char_code),
    .last_char     (last_char),
    .cell_index    (cell_index),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .cell_data     (cell_data),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .hw_cursor_pos (hw_cursor_pos)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // cursor down one row, scrolling the image on the last row
  function automatic void feed_line();
    if (cur_row + 1 >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_img[i] = screen_img[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_img[i] = {fill_attr_q, 8'h00};
    end else begin
      cur_row++;
    end
  endfunction

  // apply one command word to the image and return the status it reports
  function automatic console_status_t advance_console(logic [1:0] op, logic [7:0] ch,
                                                      bit last, logic [10:0] idx);
    console_status_t res;
    res.cell_val = 16'h0000;
    case (op)
      OP_PUT: begin
        if (ch == CH_LF) begin
          feed_line();
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else begin
          // wrap before writing when the row is full
          if (cur_col >= COLS) begin
            feed_line();
            cur_col = 0;
          end
          screen_img[cur_row * COLS + cur_col] = {text_attr_q, ch};
          cur_col++;
        end
        if (last) hw_pos = cur_row * COLS + cur_col;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_img[i] = {fill_attr_q, 8'h00};
        cur_col = 0;
        cur_row = 0;
        hw_pos  = 0;
      end
      OP_READ: begin
        if (idx < CELLS) res.cell_val = screen_img[idx];
      end
      default: ;
    endcase
    res.col = cur_col[6:0];
    res.row = cur_row[4:0];
    res.hw  = hw_pos[10:0];
    return res;
  endfunction

  // send one word, with random idle cycles ahead of it while gaps are on
  task automatic send_word(input logic [1:0] op, input logic [7:0] ch, input bit last,
                           input logic [10:0] idx, input bit typed,
                           input console_status_t typed_want);
    console_status_t want;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    last_char  <= last;
    cell_index <= idx;
    do @(posedge clk); while (busy);
    want = advance_console(op, ch, last, idx);
    if (typed) want = typed_want;
    pending_status.push_back(want);
  endtask

  // attribute writes, only once the engine has gone idle
  task automatic write_attrs(input logic [7:0] text_val, input logic [7:0] fill_val);
    @(negedge clk);
    start <= 1'b0;
    while (pending_status.size() != 0 || busy) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_TEXT_ATTR;
    cfg_data  <= text_val;
    @(negedge clk);
    cfg_index <= REG_FILL_ATTR;
    cfg_data  <= fill_val;
    @(negedge clk);
    cfg_write   <= 1'b0;
    text_attr_q = text_val;
    fill_attr_q = fill_val;
  endtask

  // result checking against the oldest expectation
  always @(posedge clk) begin : watch_results
    console_status_t want;
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
      end else begin
        want = pending_status.pop_front();
        if (cell_data !== want.cell_val) begin
          $error("cell_data: expected %h, got %h", want.cell_val, cell_data);
          errors++;
        end
        if (cursor_col !== want.col) begin
          $error("cursor_col: expected %0d, got %0d", want.col, cursor_col);
          errors++;
        end
        if (cursor_row !== want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
          errors++;
        end
        if (hw_cursor_pos !== want.hw) begin
          $error("hw_cursor_pos: expected %0d, got %0d", want.hw, hw_cursor_pos);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  text_set [PHASES];
    logic [7:0]  fill_set [PHASES];
    logic [1:0]  op;
    logic [7:0]  ch;
    bit          last;
    logic [10:0] idx;
    int          roll;

    errors      = 0;
    cycles      = 0;
    gaps_on     = 1'b1;
    cur_col     = 0;
    cur_row     = 0;
    hw_pos      = 0;
    text_attr_q = 8'd7;
    fill_attr_q = 8'd7;
    for (int i = 0; i < CELLS; i++) screen_img[i] = 16'h0000;

    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_PUT;
    char_code  = 8'h00;
    last_char  = 1'b0;
    cell_index = 11'd0;
    cfg_write  = 1'b0;
    cfg_index  = REG_TEXT_ATTR;
    cfg_data   = 8'h00;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[r]) begin
      repeat (plan[r].reps)
        send_word(plan[r].op, plan[r].ch, plan[r].last, plan[r].idx, plan[r].typed,
                  '{plan[r].w_cell, plan[r].w_col, plan[r].w_row, plan[r].w_hw});
    end

    // attribute settings per phase, extremes included
    text_set = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
    fill_set = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};
    text_set[2] = 8'($urandom_range(255));
    fill_set[2] = 8'($urandom_range(255));
    text_set[4] = 8'($urandom_range(255));
    fill_set[4] = 8'($urandom_range(255));
    text_set[5] = 8'($urandom_range(255));
    fill_set[5] = 8'($urandom_range(255));

    // random phases: mostly message text, some reads, rare clears and noise
    for (int p = 0; p < PHASES; p++) begin
      write_attrs(text_set[p], fill_set[p]);
      gaps_on = (p != 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(99);
        ch   = 8'($urandom_range(255));
        last = 1'($urandom_range(1));
        idx  = 11'($urandom_range(2047));
        if (roll < 2) begin
          op = OP_CLEAR;
        end else if (roll < 4) begin
          op = OP_NONE;
        end else if (roll < 18) begin
          op   = OP_READ;
          roll = $urandom_range(9);
          if (roll < 5)
            idx = 11'(cur_row * COLS + $urandom_range(COLS - 1));
          else if (roll < 6)
            idx = 11'($urandom_range(2047, CELLS));
          else
            idx = 11'($urandom_range(CELLS - 1));
        end else begin
          op   = OP_PUT;
          roll = $urandom_range(99);
          if (roll < 8)
            ch = CH_LF;
          else if (roll < 13)
            ch = CH_CR;
          last = ($urandom_range(7) == 0);
        end
        send_word(op, ch, last, idx, 1'b0, '0);
      end
    end

    // drain
    @(negedge clk);
    start <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer_unit.sv
dv/testbench.sv
